### sv/sil_pkg.sv
// ----------------------------------------------------------------------------
// sil_pkg
// Types and codes shared by the sorted insert list cells, top level and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sil_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DUMP   = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] entry_value;
        logic [POS_W-1:0]         position;
        logic                     last;
        logic [STAT_W-1:0]        status;
    } rsp_t;

    typedef struct packed {
        logic ins;
        logic rot;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### sv/sil_cell.sv
// ----------------------------------------------------------------------------
// sil_cell
// One slot of the sorted chain: compares its entry with the incoming value,
// shifts up on insert and rotates toward slot zero on dump.
// ----------------------------------------------------------------------------
`default_nettype none

module sil_cell (
    input  wire                                    clk,
    input  wire sil_pkg::cell_ctrl_t               ctrl,
    input  wire logic signed [sil_pkg::DATA_W-1:0] new_value,
    input  wire logic signed [sil_pkg::DATA_W-1:0] prev_value,
    input  wire logic signed [sil_pkg::DATA_W-1:0] rot_value,
    input  wire logic                              prev_take,
    input  wire logic                              valid,
    output logic signed [sil_pkg::DATA_W-1:0]      value,
    output logic                                   take
);

    logic signed [sil_pkg::DATA_W-1:0] value_reg;
    logic signed [sil_pkg::DATA_W-1:0] value_next;

    assign take  = !valid || (value_reg >= new_value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins && take)
        begin
            value_next = prev_take ? prev_value : new_value;
        end
        else if (ctrl.rot)
        begin
            value_next = rot_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

### sv/sorted_insert_list.sv
// An insert beat's result is registered and shows in the cycle after acceptance.
// Throughput: one insert per cycle while the result slot is free; the slot search is combinational.
// A dump first enters the dump state, then gives one entry per cycle while the result
// slot is free, as the chain rotates toward slot zero; no input is taken meanwhile.
// Reset clears the state, entry count and result valid flag; the result register and
// cell contents are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
// sorted_insert_list
// Bounded ascending store of signed values built as a chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_list #(
    parameter int DEPTH = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire sil_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output sil_pkg::rsp_t       rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic                              state_reg;
    logic                              state_next;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [IDX_W-1:0]                  dump_idx_reg;
    logic [IDX_W-1:0]                  dump_idx_next;
    logic                              rsp_valid_reg;
    logic                              rsp_valid_next;
    sil_pkg::rsp_t                     rsp_reg;
    sil_pkg::rsp_t                     rsp_next;

    logic                              slot_free;
    logic                              accept;
    logic                              full;
    logic                              dump_last;
    sil_pkg::cell_ctrl_t               ctrl;
    logic [DEPTH-1:0]                  valid;
    logic [DEPTH-1:0]                  take;
    logic [DEPTH-1:0]                  edge_hit;
    logic [IDX_W-1:0]                  ins_idx;
    logic signed [sil_pkg::DATA_W-1:0] cell_value [DEPTH];

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign dump_last = ((CNT_W'(dump_idx_reg) + CNT_W'(1)) == count_reg);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign valid[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_head
                assign edge_hit[gi] = take[gi];
                sil_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .new_value  (req.value),
                    .prev_value (req.value),
                    .rot_value  (valid[1] ? cell_value[1] : cell_value[0]),
                    .prev_take  (1'b0),
                    .valid      (valid[gi]),
                    .value      (cell_value[gi]),
                    .take       (take[gi])
                );
            end
            else if (gi == DEPTH - 1)
            begin : g_tail
                assign edge_hit[gi] = take[gi] && !take[gi-1];
                sil_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .new_value  (req.value),
                    .prev_value (cell_value[gi-1]),
                    .rot_value  (cell_value[0]),
                    .prev_take  (take[gi-1]),
                    .valid      (valid[gi]),
                    .value      (cell_value[gi]),
                    .take       (take[gi])
                );
            end
            else
            begin : g_mid
                assign edge_hit[gi] = take[gi] && !take[gi-1];
                sil_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .new_value  (req.value),
                    .prev_value (cell_value[gi-1]),
                    .rot_value  (valid[gi+1] ? cell_value[gi+1] : cell_value[0]),
                    .prev_take  (take[gi-1]),
                    .valid      (valid[gi]),
                    .value      (cell_value[gi]),
                    .take       (take[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        ins_idx = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            if (edge_hit[j])
            begin
                ins_idx = ins_idx | IDX_W'(j);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ctrl           = '0;

        if (slot_free)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.mode == sil_pkg::MODE_INSERT)
                    begin
                        rsp_valid_next       = 1'b1;
                        rsp_next.entry_value = req.value;
                        rsp_next.last        = 1'b1;
                        if (full)
                        begin
                            rsp_next.position = '0;
                            rsp_next.status   = sil_pkg::STAT_FULL;
                        end
                        else
                        begin
                            ctrl.ins          = 1'b1;
                            count_next        = count_reg + CNT_W'(1);
                            rsp_next.position = sil_pkg::POS_W'(ins_idx);
                            rsp_next.status   = sil_pkg::STAT_OK;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        rsp_valid_next       = 1'b1;
                        rsp_next.entry_value = '0;
                        rsp_next.position    = '0;
                        rsp_next.last        = 1'b1;
                        rsp_next.status      = sil_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        state_next    = ST_DUMP;
                        dump_idx_next = '0;
                    end
                end
            end
            ST_DUMP:
            begin
                if (slot_free)
                begin
                    ctrl.rot             = 1'b1;
                    rsp_valid_next       = 1'b1;
                    rsp_next.entry_value = cell_value[0];
                    rsp_next.position    = sil_pkg::POS_W'(dump_idx_reg);
                    rsp_next.last        = dump_last;
                    rsp_next.status      = sil_pkg::STAT_OK;
                    dump_idx_next        = dump_idx_reg + IDX_W'(1);
                    if (dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

### sv/sil_check.sv
// ----------------------------------------------------------------------------
// sil_check
// Port-level checks for the sorted insert list, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sil_check (
    input wire                clk,
    input wire                rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire sil_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire sil_pkg::rsp_t rsp
);

    // hold a stalled result beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == sil_pkg::STAT_FULL)
        |-> rsp.last && (rsp.position == '0))
        else $error("dropped insert not reported as single beat at position zero");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == sil_pkg::STAT_EMPTY)
        |-> rsp.last && (rsp.position == '0) && (rsp.entry_value == '0))
        else $error("empty dump beat malformed");

    a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> !req_ready)
        else $error("input taken in the middle of a dump");

    a_dump_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp.last
        |=> !rsp_valid || ((rsp.status == sil_pkg::STAT_OK)
            && (rsp.position == $past(rsp.position) + 5'd1)))
        else $error("dump positions out of sequence");

endmodule

bind sorted_insert_list sil_check u_sil_check (.*);

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted insert list.
// Random valid/ready traffic on both channels drives inserts and dumps. A
// scoreboard keeps its own ascending store, works out every result beat of
// each accepted request and checks the returned beats in order, field by field.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH   = 16;
    localparam int PHASE_ITEMS   = 84;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic          drain_first;
        sil_pkg::req_t item;
    } beat_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          rsp_ready = 1'b0;
    sil_pkg::req_t req       = '0;
    logic          req_ready;
    logic          rsp_valid;
    sil_pkg::rsp_t rsp;

    beat_t         pending_beats[$];
    sil_pkg::rsp_t expected_rsp[$];

    logic signed [sil_pkg::DATA_W-1:0] shadow_store [STORE_DEPTH];
    int    shadow_count    = 0;

    int    send_idle_pct   = 37;
    int    recv_idle_pct   = 66;
    int    issued_count    = 0;
    int    accepted_count  = 0;
    int    idle_cycles     = 0;
    int    mismatch_count  = 0;
    int    results_checked = 0;
    int    inserts_stored  = 0;
    int    inserts_dropped = 0;
    int    dumps_full      = 0;
    int    dumps_empty     = 0;

    sorted_insert_list #(
        .DEPTH(STORE_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always #5 clk = ~clk;

    function automatic sil_pkg::rsp_t make_rsp(logic signed [sil_pkg::DATA_W-1:0] val,
                                               int pos, logic last,
                                               logic [sil_pkg::STAT_W-1:0] status);
        sil_pkg::rsp_t r;
        r.entry_value = val;
        r.position    = sil_pkg::POS_W'(pos);
        r.last        = last;
        r.status      = status;
        return r;
    endfunction

    function automatic void predict_sorted_results(sil_pkg::req_t item);
        int slot;
        if (item.mode == sil_pkg::MODE_INSERT)
        begin
            if (shadow_count >= STORE_DEPTH)
            begin
                expected_rsp.push_back(make_rsp(item.value, 0, 1'b1, sil_pkg::STAT_FULL));
                inserts_dropped++;
            end
            else
            begin
                slot = shadow_count;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_store[i] >= item.value)
                    begin
                        slot = i;
                        break;
                    end
                end
                for (int i = shadow_count; i > slot; i--)
                    shadow_store[i] = shadow_store[i-1];
                shadow_store[slot] = item.value;
                shadow_count++;
                expected_rsp.push_back(make_rsp(item.value, slot, 1'b1, sil_pkg::STAT_OK));
                inserts_stored++;
            end
        end
        else if (shadow_count == 0)
        begin
            expected_rsp.push_back(make_rsp('0, 0, 1'b1, sil_pkg::STAT_EMPTY));
            dumps_empty++;
        end
        else
        begin
            for (int i = 0; i < shadow_count; i++)
                expected_rsp.push_back(make_rsp(shadow_store[i], i,
                                                i == shadow_count - 1, sil_pkg::STAT_OK));
            dumps_full++;
        end
    endfunction

    task automatic check_result_beat(sil_pkg::rsp_t got);
        sil_pkg::rsp_t want;
        if (expected_rsp.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: unexpected result value=%0d pos=%0d last=%0b status=%0d",
                         $realtime, got.entry_value, got.position, got.last, got.status);
        end
        else
        begin
            want = expected_rsp.pop_front();
            results_checked++;
            if (got.entry_value !== want.entry_value || got.position !== want.position
                || got.last !== want.last || got.status !== want.status)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display({"%0t: mismatch exp value=%0d pos=%0d last=%0b status=%0d,",
                              " got value=%0d pos=%0d last=%0b status=%0d"},
                             $realtime, want.entry_value, want.position, want.last,
                             want.status, got.entry_value, got.position, got.last,
                             got.status);
            end
        end
    endtask

    task automatic push_beat(logic mode, logic signed [sil_pkg::DATA_W-1:0] val,
                             logic drain);
        beat_t b;
        b.drain_first = drain;
        b.item.mode   = mode;
        b.item.value  = val;
        pending_beats.push_back(b);
    endtask

    task automatic push_random_phase(int count);
        logic signed [sil_pkg::DATA_W-1:0] val;
        logic                              mode;
        for (int n = 0; n < count; n++)
        begin
            mode = ($urandom_range(99) < 45) ? sil_pkg::MODE_DUMP : sil_pkg::MODE_INSERT;
            case ($urandom_range(7))
                0:       val = 32'sh7fffffff;
                1:       val = 32'sh80000000;
                2:       val = $signed(32'($urandom_range(8))) - 4;
                default: val = $urandom;
            endcase
            push_beat(mode, val, n == 0);
        end
    endtask

    task automatic wait_phase_sent;
        while (pending_beats.size() != 0 || accepted_count != issued_count)
            @(posedge clk);
    endtask

    // drive: new request once the previous beat is taken, hold otherwise
    always @(negedge clk)
    begin : drive_req
        beat_t next_beat;
        if (rst_n)
        begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (accepted_count == issued_count)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct
                    && !(pending_beats[0].drain_first && expected_rsp.size() != 0))
                begin
                    next_beat = pending_beats.pop_front();
                    req       <= next_beat.item;
                    req_valid <= 1'b1;
                    issued_count++;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                check_result_beat(rsp);
            if (req_valid && req_ready)
            begin
                predict_sorted_results(req);
                accepted_count++;
            end
            if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, expected_rsp.size());
                $display("FAIL sorted_insert_list");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty store, first insert, equals, extremes, full store
        push_beat(sil_pkg::MODE_DUMP,   32'sh1234abcd, 1'b0);
        push_beat(sil_pkg::MODE_INSERT, 32'sd0,        1'b0);
        push_beat(sil_pkg::MODE_INSERT, 32'sd0,        1'b0);
        push_beat(sil_pkg::MODE_INSERT, 32'sh7fffffff, 1'b0);
        push_beat(sil_pkg::MODE_INSERT, 32'sh80000000, 1'b0);
        push_beat(sil_pkg::MODE_INSERT, -32'sd1,       1'b0);
        push_beat(sil_pkg::MODE_INSERT, 32'sd1,        1'b0);
        push_beat(sil_pkg::MODE_DUMP,   32'sh0,        1'b0);
        push_beat(sil_pkg::MODE_INSERT, 32'sh7fffffff, 1'b0);
        push_beat(sil_pkg::MODE_INSERT, 32'sh80000000, 1'b0);
        for (int n = 0; n < 8; n++)
            push_beat(sil_pkg::MODE_INSERT, $signed(32'($urandom_range(6))) - 3, 1'b0);
        push_beat(sil_pkg::MODE_DUMP,   32'shffffffff, 1'b1);
        push_beat(sil_pkg::MODE_INSERT, 32'sh80000000, 1'b0);
        push_beat(sil_pkg::MODE_INSERT, 32'sh7fffffff, 1'b0);
        push_beat(sil_pkg::MODE_INSERT, 32'sd0,        1'b0);
        push_beat(sil_pkg::MODE_DUMP,   32'sh55555555, 1'b0);

        push_random_phase(PHASE_ITEMS);
        wait_phase_sent();

        send_idle_pct = 66;
        recv_idle_pct = 37;
        push_random_phase(PHASE_ITEMS);
        wait_phase_sent();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random_phase(PHASE_ITEMS);
        wait_phase_sent();

        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d inserts stored, %0d dropped on full store,",
                 accepted_count, inserts_stored, inserts_dropped);
        $display("%0d dumps with entries, %0d of an empty store, %0d result beats checked",
                 dumps_full, dumps_empty, results_checked);
        if (mismatch_count == 0)
            $display("PASS sorted_insert_list");
        else
            $display("FAIL sorted_insert_list");
        $finish;
    end

endmodule

### files.f
sv/sil_pkg.sv
sv/sil_cell.sv
sv/sorted_insert_list.sv
sv/sil_check.sv
test/tb.sv
